// ===== design/bsl_pkg.sv =====
`timescale 1ns / 1ps
package bsl_pkg;
    localparam int MAX_RECORDS = 64;
    localparam int MAX_ADDRS   = 32;
    localparam int REC_W  = $clog2(MAX_RECORDS);
    localparam int SLOT_W = $clog2(MAX_ADDRS);
    localparam int RCNT_W = $clog2(MAX_RECORDS + 1);
    localparam int ACNT_W = $clog2(MAX_ADDRS + 1);
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ADDR_FULL = 2'd1,
        ST_LOG_FULL  = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic {
        CFG_START = 1'b0,
        CFG_TICK  = 1'b1
    } t_cfg_idx;
endpackage

// ===== design/beacon_sighting_log_unit.sv =====
`timescale 1ns / 1ps
// Beacon sighting log.
// Input channel (i_valid / o_stall) carries one request per transfer: add a
// sighting, clear the counters, or read a record. Every request produces exactly
// one result transfer on the output channel (o_valid / i_stall).
// The block handles one request at a time. An add searches the address table one
// entry per cycle, then runs a radix-2 divider, one quotient bit per cycle, to
// form the age in ms. An add that is rejected ends after the search and the
// table-full and log-full check, without the divider. A read passes through the
// registered record and address memories. A clear or an unused request goes
// straight to the output. After its result is taken, the block returns to idle
// and takes the next request.
// o_stall is high from the transfer until the result has been taken. While the
// receiver stalls, the result holds in the output register.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always accepted and must
// only be issued while the block is idle. Index 0 is the scan start time, index 1
// the tick rate. Synchronous reset clears counts, flag, selection and control.
// The address table has no reset; record stores are only read below the count.
module beacon_sighting_log_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [47:0] i_device_addr,
    input  logic signed [7:0] i_signal_strength,
    input  logic [31:0] i_time_stamp,
    input  logic [15:0] i_record_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [6:0]  o_record_count,
    output logic [5:0]  o_distinct_count,
    output logic        o_more_devices,
    output logic [47:0] o_rec_addr,
    output logic signed [7:0] o_rec_strength,
    output logic [31:0] o_rec_age_ms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEARCH, S_CHECK, S_MUL, S_DIV, S_STORE,
        S_RD_REC, S_RD_ADDR, S_RD_OUT, S_OUT
    } t_state;

    t_state r_state;
    logic [31:0] r_start, r_tick;
    logic [47:0] r_addr_in;
    logic [7:0]  r_str_in;
    logic [31:0] r_ts;
    logic [RCNT_W-1:0] r_log_count;
    logic [ACNT_W-1:0] r_addr_count;
    logic        r_ovf;
    logic [REC_W-1:0] r_sel;
    logic [ACNT_W-1:0] r_idx;
    logic        r_found;
    logic [SLOT_W-1:0] r_slot;
    logic [31:0] r_rem, r_quo;
    logic [5:0]  r_bit;
    logic        r_valid;
    logic [1:0]  r_status;
    logic [47:0] r_oaddr;
    logic [7:0]  r_ostr;
    logic [31:0] r_oage;
    logic        r_rd_ok;

    logic [47:0] addr_mem [MAX_ADDRS];
    logic [SLOT_W-1:0] slot_mem [MAX_RECORDS];
    logic [7:0]  str_mem [MAX_RECORDS];
    logic [31:0] age_mem [MAX_RECORDS];
    logic [47:0] r_addr_q;
    logic [SLOT_W-1:0] r_slot_q;
    logic [7:0]  r_str_q;
    logic [31:0] r_age_q;

    logic              addr_we, rec_we;
    logic [SLOT_W-1:0] addr_ra;
    logic [REC_W-1:0]  rec_ra;
    logic [32:0]       div_try;

    // Address memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (addr_we) begin
            addr_mem[r_slot] <= r_addr_in;
        end
        r_addr_q <= addr_mem[addr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            slot_mem[r_log_count[REC_W-1:0]] <= r_slot;
            str_mem[r_log_count[REC_W-1:0]]  <= 8'd0 - r_str_in;
            age_mem[r_log_count[REC_W-1:0]]  <= r_quo;
        end
        r_slot_q <= slot_mem[rec_ra];
        r_str_q  <= str_mem[rec_ra];
        r_age_q  <= age_mem[rec_ra];
    end

    assign addr_we = (r_state == S_STORE) && !r_found;
    assign rec_we  = (r_state == S_STORE);
    // During search the address follows the scan index; on read it is the slot.
    assign addr_ra = (r_state == S_RD_ADDR) ? r_slot_q : r_idx[SLOT_W-1:0];
    assign rec_ra  = r_sel;
    // Restoring division step: shift in one dividend bit, try to subtract.
    assign div_try = {r_rem, r_quo[31]} - {1'b0, r_tick};

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_tick <= 32'd48000000;
            r_log_count <= '0;
            r_addr_count <= '0;
            r_ovf <= 1'b0;
            r_sel <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_START: r_start <= i_cfg_data;
                    CFG_TICK:  r_tick <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_addr_in <= i_device_addr;
                        r_str_in <= i_signal_strength;
                        r_ts <= i_time_stamp;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_oaddr <= '0;
                        r_ostr <= '0;
                        r_oage <= '0;
                        r_status <= ST_OK;
                        case (t_func'(i_func))
                            FUNC_ADD:   r_state <= S_SEARCH;
                            FUNC_CLEAR: begin
                                r_log_count <= '0;
                                r_addr_count <= '0;
                                r_ovf <= 1'b0;
                                r_sel <= '0;
                                r_state <= S_OUT;
                            end
                            FUNC_READ: begin
                                if (i_record_index < 16'(r_log_count)) begin
                                    r_sel <= i_record_index[REC_W-1:0];
                                end else begin
                                    r_status <= ST_RANGE;
                                end
                                r_rd_ok <= (r_log_count != '0);
                                r_state <= S_RD_REC;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SEARCH: begin
                    // Read data for entry r_idx-1 arrives now; compare it.
                    if (r_idx != '0 && r_addr_q == r_addr_in) begin
                        r_found <= 1'b1;
                        r_slot <= SLOT_W'(r_idx - 1'b1);
                        r_state <= S_CHECK;
                    end else if (r_idx == r_addr_count) begin
                        r_slot <= SLOT_W'(r_addr_count);
                        r_state <= S_CHECK;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (!r_found && r_addr_count >= ACNT_W'(MAX_ADDRS)) begin
                        r_ovf <= 1'b1;
                        r_status <= ST_ADDR_FULL;
                        r_state <= S_OUT;
                    end else if (r_log_count >= RCNT_W'(MAX_RECORDS)) begin
                        r_status <= ST_LOG_FULL;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_quo <= 32'((r_ts - r_start) * MS_PER_S);
                    r_rem <= '0;
                    r_bit <= 6'd32;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!div_try[32]) begin
                        r_rem <= div_try[31:0];
                    end else begin
                        r_rem <= {r_rem[30:0], r_quo[31]};
                    end
                    r_quo <= {r_quo[30:0], !div_try[32]};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd1) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (!r_found) begin
                        r_addr_count <= r_addr_count + 1'b1;
                    end
                    r_log_count <= r_log_count + 1'b1;
                    r_state <= S_OUT;
                end
                S_RD_REC: r_state <= S_RD_ADDR;
                S_RD_ADDR: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    if (r_rd_ok) begin
                        r_oaddr <= r_addr_q;
                        r_ostr <= r_str_q;
                        r_oage <= r_age_q;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid) begin
                        r_valid <= 1'b1;
                    end else if (!i_stall) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_record_count   = 7'(r_log_count);
    assign o_distinct_count = 6'(r_addr_count);
    assign o_more_devices   = r_ovf;
    assign o_rec_addr       = r_oaddr;
    assign o_rec_strength   = r_ostr;
    assign o_rec_age_ms     = r_oage;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_log_count <= RCNT_W'(MAX_RECORDS) && r_addr_count <= ACNT_W'(MAX_ADDRS))
        else $error("count beyond capacity");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_OUT)
        else $error("result shown outside output state");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid && $stable(r_status))
        else $error("stalled result changed");
endmodule

// ===== tb/beacon_sighting_log_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the beacon sighting log.
// Requests go in on the i_valid / o_stall channel, and results come back on the
// o_valid / i_stall channel. Each accepted request is run through a local model
// of the log. The model keeps its own address table, record stores, counts and
// registers, and the expected result is queued. Each result transfer is checked
// field by field against the oldest queued expectation.
module beacon_sighting_log_unit_tb;
    import bsl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 80;      // longer than the longest add
    localparam int RAND_ITEMS  = 1050;
    localparam int N_PHASES    = 5;
    localparam int POOL_SIZE   = 40;      // more than the table holds

    typedef struct {
        t_func              func;
        logic [47:0]        addr;
        logic signed [7:0]  strength;
        logic [31:0]        stamp;
        logic [15:0]        index;
    } t_request;

    typedef struct {
        t_status            status;
        logic [6:0]         rcount;
        logic [5:0]         dcount;
        logic               more;
        logic [47:0]        raddr;
        logic signed [7:0]  rstrength;
        logic [31:0]        rage;
    } t_sighting_result;

    // One directed row. When typed is set, the result is written out by hand.
    typedef struct {
        t_request           req;
        bit                 typed;
        t_sighting_result   res;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_func;
    logic [47:0]        i_device_addr;
    logic signed [7:0]  i_signal_strength;
    logic [31:0]        i_time_stamp;
    logic [15:0]        i_record_index;
    logic               o_valid;
    logic               i_stall;
    logic [1:0]         o_status;
    logic [6:0]         o_record_count;
    logic [5:0]         o_distinct_count;
    logic               o_more_devices;
    logic [47:0]        o_rec_addr;
    logic signed [7:0]  o_rec_strength;
    logic [31:0]        o_rec_age_ms;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [0:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    beacon_sighting_log_unit uut (.*);

    // Local copy of the log state and the two registers.
    logic [31:0]        scan_start;
    logic [31:0]        ticks_per_s;
    logic [47:0]        known_addrs [MAX_ADDRS];
    logic [4:0]         rec_slot [MAX_RECORDS];
    logic [7:0]         rec_neg_strength [MAX_RECORDS];
    logic [31:0]        rec_age [MAX_RECORDS];
    int unsigned        n_records;
    int unsigned        n_addrs;
    logic               lost_addr;
    int unsigned        selected;

    t_sighting_result   pending_results [$];
    logic [47:0]        addr_pool [POOL_SIZE];
    int unsigned        cycles;
    int unsigned        errors;
    int unsigned        sent;
    int unsigned        checked;
    int unsigned        n_full_table;
    int unsigned        n_full_log;
    int unsigned        burst_left;

    function automatic logic [31:0] age_in_ms(logic [31:0] stamp);
        logic [31:0] scaled;
        scaled = (stamp - scan_start) * 32'(MS_PER_S);
        if (ticks_per_s == 32'd0) begin
            return 32'hFFFF_FFFF;
        end
        return scaled / ticks_per_s;
    endfunction

    // Applies one request to the local log and returns the result it should give.
    function automatic t_sighting_result log_request(t_request r);
        t_sighting_result res;
        int unsigned slot;
        bit found;
        res = '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0};
        case (r.func)
            FUNC_ADD: begin
                slot = n_addrs;
                found = 0;
                for (int k = 0; k < n_addrs; k++) begin
                    if (!found && known_addrs[k] == r.addr) begin
                        slot = k;
                        found = 1;
                    end
                end
                if (!found && n_addrs >= MAX_ADDRS) begin
                    lost_addr = 1'b1;
                    res.status = ST_ADDR_FULL;
                end else if (n_records >= MAX_RECORDS) begin
                    res.status = ST_LOG_FULL;
                end else begin
                    if (!found) begin
                        known_addrs[slot] = r.addr;
                        n_addrs++;
                    end
                    rec_slot[n_records] = 5'(slot);
                    rec_neg_strength[n_records] = 8'd0 - 8'(r.strength);
                    rec_age[n_records] = age_in_ms(r.stamp);
                    n_records++;
                end
            end
            FUNC_CLEAR: begin
                n_records = 0;
                n_addrs = 0;
                lost_addr = 1'b0;
                selected = 0;
            end
            FUNC_READ: begin
                if (r.index < n_records) begin
                    selected = r.index;
                end else begin
                    res.status = ST_RANGE;
                end
                if (n_records > 0 && selected < n_records) begin
                    res.raddr = known_addrs[rec_slot[selected]];
                    res.rstrength = rec_neg_strength[selected];
                    res.rage = rec_age[selected];
                end
            end
            default: ;
        endcase
        res.rcount = 7'(n_records);
        res.dcount = 6'(n_addrs);
        res.more = lost_addr;
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver stall: a mode is picked for each stretch of cycles, so that there
    // are stretches with no stall, light random stalls and long holds.
    int unsigned stall_mode;
    int unsigned stall_stretch;
    always @(negedge i_clk) begin
        if (stall_stretch == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_stretch = $urandom_range(20, 200);
        end
        stall_stretch--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 15) != 0);
        endcase
    end

    // Result checker: every result transfer is matched with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d",
                         $time, o_status);
                errors++;
            end else begin
                t_sighting_result e;
                e = pending_results.pop_front();
                checked++;
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, o_status);
                    errors++;
                end
                if (o_record_count !== e.rcount) begin
                    $display("%0t: record_count expected %0d actual %0d",
                             $time, e.rcount, o_record_count);
                    errors++;
                end
                if (o_distinct_count !== e.dcount) begin
                    $display("%0t: distinct_count expected %0d actual %0d",
                             $time, e.dcount, o_distinct_count);
                    errors++;
                end
                if (o_more_devices !== e.more) begin
                    $display("%0t: more_devices expected %0d actual %0d",
                             $time, e.more, o_more_devices);
                    errors++;
                end
                if (o_rec_addr !== e.raddr) begin
                    $display("%0t: rec_addr expected %h actual %h", $time, e.raddr, o_rec_addr);
                    errors++;
                end
                if (o_rec_strength !== e.rstrength) begin
                    $display("%0t: rec_strength expected %0d actual %0d",
                             $time, e.rstrength, o_rec_strength);
                    errors++;
                end
                if (o_rec_age_ms !== e.rage) begin
                    $display("%0t: rec_age_ms expected %0d actual %0d",
                             $time, e.rage, o_rec_age_ms);
                    errors++;
                end
            end
        end
    end

    // Run limit, generous against the slowest legal run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("beacon_sighting_log_unit_tb NOT OK");
            $finish;
        end
    end

    // Register write, only while the block is idle. Called at a falling edge.
    task automatic write_register(t_cfg_idx idx, logic [31:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_START) begin
            scan_start = value;
        end else begin
            ticks_per_s = value;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drives one request and holds it until the transfer. The sender works in
    // bursts; between bursts it drops valid for a random gap. Called at a
    // falling edge and returns at one.
    task automatic send_request(t_request r, bit typed, t_sighting_result hand_res);
        t_sighting_result res;
        i_valid = 1'b1;
        i_func = r.func;
        i_device_addr = r.addr;
        i_signal_strength = r.strength;
        i_time_stamp = r.stamp;
        i_record_index = r.index;
        do @(posedge i_clk); while (o_stall);
        res = log_request(r);
        if (res.status == ST_ADDR_FULL) n_full_table++;
        if (res.status == ST_LOG_FULL) n_full_log++;
        pending_results.push_back(typed ? hand_res : res);
        sent++;
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        // The last request may still be on the bus; take it away first.
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        // A stray late result would still show up within the settle window.
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic t_request random_request(int unsigned fill_bias);
        t_request r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        r.addr = $urandom_range(0, 3) == 0 ? {16'($urandom), 32'($urandom)}
                                            : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.strength = 8'($urandom);
        r.stamp = $urandom;
        r.index = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                            : 16'($urandom_range(0, MAX_RECORDS));
        if (pick < fill_bias) begin
            r.func = FUNC_ADD;
        end else if (pick < 96) begin
            r.func = FUNC_READ;
        end else if (pick < 98) begin
            r.func = FUNC_CLEAR;
        end else begin
            r.func = FUNC_NONE;
        end
        return r;
    endfunction

    t_directed_row directed [] = '{
        // Read of an empty log returns zeros and the range status.
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd0}, 1,
          '{ST_RANGE, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        // The unused function changes nothing.
        '{'{FUNC_NONE, 48'hFFFF_FFFF_FFFF, -8'sd1, 32'hFFFF_FFFF, 16'hFFFF}, 1,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_ADD, 48'd0, -8'sd128, 32'd0, 16'd0}, 1,
          '{ST_OK, 7'd1, 6'd1, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_ADD, 48'hFFFF_FFFF_FFFF, 8'sd127, 32'hFFFF_FFFF, 16'd0}, 1,
          '{ST_OK, 7'd2, 6'd2, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_ADD, 48'd0, 8'sd0, 32'd48000000, 16'd0}, 1,
          '{ST_OK, 7'd3, 6'd2, 1'b0, 48'd0, 8'sd0, 32'd0}},
        // Negating the most negative strength wraps back onto itself.
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd0}, 1,
          '{ST_OK, 7'd3, 6'd2, 1'b0, 48'd0, -8'sd128, 32'd0}},
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd1}, 0,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        // Out of range keeps the selection and still returns that record.
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'hFFFF}, 0,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd3}, 0,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd2}, 0,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_CLEAR, 48'd0, 8'sd0, 32'd0, 16'd0}, 1,
          '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}},
        '{'{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'd0}, 1,
          '{ST_RANGE, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0}}
    };

    initial begin
        t_request r;
        t_sighting_result none;
        logic [31:0] starts [N_PHASES];
        logic [31:0] rates [N_PHASES];
        int unsigned per_phase;

        none = '{ST_OK, 7'd0, 6'd0, 1'b0, 48'd0, 8'sd0, 32'd0};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_NONE;
        i_device_addr = '0;
        i_signal_strength = '0;
        i_time_stamp = '0;
        i_record_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_START;
        i_cfg_data = '0;
        sent = 0;
        n_full_table = 0;
        n_full_log = 0;
        burst_left = 0;
        scan_start = 32'd0;
        ticks_per_s = 32'd48000000;
        n_records = 0;
        n_addrs = 0;
        lost_addr = 1'b0;
        selected = 0;
        addr_pool[0] = 48'd0;
        addr_pool[1] = 48'hFFFF_FFFF_FFFF;
        for (int k = 2; k < POOL_SIZE; k++) begin
            addr_pool[k] = {16'($urandom), 32'($urandom)};
        end

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows under the reset register values.
        foreach (directed[n]) begin
            send_request(directed[n].req, directed[n].typed, directed[n].res);
        end

        // Fill the table past its end and the log to the brim, so that both
        // full cases show up: first 33 distinct addresses, then repeats.
        for (int k = 0; k < MAX_ADDRS + 1; k++) begin
            r = '{FUNC_ADD, 48'h1000 + 48'(k), 8'($urandom), $urandom, 16'd0};
            send_request(r, 0, none);
        end
        for (int k = 0; k < MAX_RECORDS - MAX_ADDRS + 1; k++) begin
            r = '{FUNC_ADD, 48'h1000 + 48'(k % 4), 8'($urandom), $urandom, 16'd0};
            send_request(r, 0, none);
        end
        r = '{FUNC_ADD, 48'h9999, 8'sd5, 32'd7, 16'd0};
        send_request(r, 0, none);
        r = '{FUNC_READ, 48'd0, 8'sd0, 32'd0, 16'(MAX_RECORDS - 1)};
        send_request(r, 0, none);

        // Register settings per phase: the reset values, both extremes, and
        // random ones.
        starts = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, $urandom};
        rates = '{32'd48000000, 32'd1, 32'hFFFF_FFFF, 32'd1000, $urandom_range(1, 32'hFFFF_FFFF)};
        per_phase = RAND_ITEMS / N_PHASES;

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_register(CFG_START, starts[p]);
            write_register(CFG_TICK, rates[p]);
            for (int k = 0; k < per_phase; k++) begin
                // Once, hold the sender back until every result is in.
                if (p == 2 && k == per_phase / 2) begin
                    i_valid = 1'b0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                send_request(random_request(p == 1 ? 80 : 60), 0, none);
            end
        end

        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        $display("Covered %0d requests and %0d checked results over %0d register settings,",
                 sent, checked, N_PHASES);
        $display("with %0d table-full and %0d log-full adds.", n_full_table, n_full_log);
        if (errors == 0) begin
            $display("beacon_sighting_log_unit_tb OK");
        end else begin
            $display("beacon_sighting_log_unit_tb NOT OK");
        end
        $finish;
    end
endmodule
